### rtl/ust_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ust_pkg: shared definitions for the unordered set table
// Opcodes, status codes, port widths and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ust_pkg;

	localparam int OPCODE_BITS     = 2;
	localparam int VALUE_PORT_BITS = 32;
	localparam int COUNT_BITS      = 6;
	localparam int STATUS_BITS     = 2;
	localparam int MAX_VALUE_BITS  = 64;

	localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_BITS-1:0] OP_DELETE = 2'd1;
	localparam logic [OPCODE_BITS-1:0] OP_QUERY  = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_EXISTS = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd3;

	// Controller to datapath.
	typedef struct packed {
		logic load;    // capture a new item, restart the scan
		logic scan;    // issue one read and compare the previous one
		logic decide;  // set status, append on insert, fetch last entry
		logic move;    // fill the hole of a delete with the last entry
	} ust_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic hit;        // compared entry matches the value
		logic scan_end;   // every live entry has been compared
		logic need_move;  // delete of a present value
	} ust_sts_t;

endpackage
`default_nettype wire

### rtl/ust_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ust_ctrl: sequencer of the unordered set table
// Steps each item through scan, decision and optional move, and strobes
// the result when the item is finished.
// ----------------------------------------------------------------------------
module ust_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ust_pkg::ust_sts_t sts,
	output ust_pkg::ust_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);
	import ust_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MOVE
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.scan   = (state_q == S_SCAN);
		cmd.decide = (state_q == S_DECIDE);
		cmd.move   = (state_q == S_MOVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.hit || sts.scan_end) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (sts.need_move) begin
						state_q <= S_MOVE;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_MOVE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

### rtl/ust_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ust_dp: datapath of the unordered set table
// Entry memory with one write and one registered read port, scan counter,
// comparator, live count and result registers.
// ----------------------------------------------------------------------------
module ust_dp #(
	parameter int CAPACITY_ENTRIES = 32,
	parameter int VALUE_BITS       = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [ust_pkg::OPCODE_BITS-1:0]     opcode,
	input  wire logic [ust_pkg::VALUE_PORT_BITS-1:0] value,
	input  wire ust_pkg::ust_cmd_t                   cmd,
	output ust_pkg::ust_sts_t                        sts,
	output logic                                     present,
	output logic [ust_pkg::COUNT_BITS-1:0]           count,
	output logic [ust_pkg::STATUS_BITS-1:0]          status
);
	import ust_pkg::*;

	localparam int AW = $clog2(CAPACITY_ENTRIES);
	localparam int CW = $clog2(CAPACITY_ENTRIES + 1);

	logic [VALUE_BITS-1:0]      mem [CAPACITY_ENTRIES];

	logic [OPCODE_BITS-1:0]     op_q;
	logic [VALUE_BITS-1:0]      val_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              rd_idx_q;
	logic [VALUE_BITS-1:0]      rd_data_s1;
	logic [AW-1:0]              cmp_idx_s1;
	logic                       cmp_vld_s1;
	logic                       found_q;
	logic [AW-1:0]              slot_q;
	logic [STATUS_BITS-1:0]     status_q;

	logic [MAX_VALUE_BITS-1:0]  value_ext;
	logic [CW-1:0]              cnt_m1;
	logic                       full;
	logic                       hit;
	logic                       ins_wr;
	logic [AW-1:0]              rd_addr;
	logic [STATUS_BITS-1:0]     status_next;
	logic [CW+COUNT_BITS-1:0]   count_ext;

	assign value_ext = {{(MAX_VALUE_BITS-VALUE_PORT_BITS){1'b0}}, value};
	assign cnt_m1    = count_q - CW'(1);
	assign full      = (count_q == CW'(CAPACITY_ENTRIES));
	assign hit       = cmp_vld_s1 && (rd_data_s1 == val_q);
	assign ins_wr    = cmd.decide && (op_q == OP_INSERT) && !found_q && !full;
	// Fetch the last live entry on a decide, else follow the scan.
	assign rd_addr   = cmd.decide ? cnt_m1[AW-1:0] : rd_idx_q[AW-1:0];

	always_comb begin
		status_next = ST_DONE;
		priority if (op_q == OP_INSERT) begin
			if (found_q)   status_next = ST_EXISTS;
			else if (full) status_next = ST_FULL;
		end else if (op_q == OP_DELETE) begin
			if (!found_q)  status_next = ST_ABSENT;
		end else begin
			status_next = ST_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_wr) begin
			mem[count_q[AW-1:0]] <= val_q;
		end else if (cmd.move) begin
			mem[slot_q] <= rd_data_s1;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
			end else if (cmd.scan) begin
				rd_idx_q   <= rd_idx_q + CW'(1);
				cmp_vld_s1 <= (rd_idx_q < count_q);
				if (hit) found_q <= 1'b1;
			end else begin
				cmp_vld_s1 <= 1'b0;
			end
			if (ins_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.move) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			val_q <= value_ext[VALUE_BITS-1:0];
		end
		if (cmd.scan) cmp_idx_s1 <= rd_idx_q[AW-1:0];
		if (cmd.scan && hit) slot_q <= cmp_idx_s1;
		if (cmd.decide) status_q <= status_next;
	end

	always_comb begin
		sts           = '0;
		sts.hit       = hit;
		sts.scan_end  = (count_q == '0) ||
		                (cmp_vld_s1 && (cmp_idx_s1 == cnt_m1[AW-1:0]));
		sts.need_move = (op_q == OP_DELETE) && found_q;
	end

	assign count_ext = {{COUNT_BITS{1'b0}}, count_q};
	assign present   = found_q;
	assign count     = count_ext[COUNT_BITS-1:0];
	assign status    = status_q;

endmodule
`default_nettype wire

### rtl/unordered_set_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Each item passes through scan, decide and, for a delete that removes a value,
// move; a miss compares every live entry, a hit ends the scan at its slot.
// One item at a time: the next start is taken in the done cycle. The entry
// scan sets the rate, one compare per cycle; results cannot stall.
// Reset clears the live count and the sequencer; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// unordered_set_table: set of distinct values in an unordered table
// Insert appends an absent value, delete fills the hole with the last entry,
// query only looks. Each transfer returns prior presence, count and status.
// ----------------------------------------------------------------------------
module unordered_set_table #(
	parameter int CAPACITY_ENTRIES = 32,
	parameter int VALUE_BITS       = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [ust_pkg::OPCODE_BITS-1:0]     opcode,
	input  wire logic [ust_pkg::VALUE_PORT_BITS-1:0] value,
	output logic                                     busy,
	output logic                                     done,
	output logic                                     present,
	output logic [ust_pkg::COUNT_BITS-1:0]           count,
	output logic [ust_pkg::STATUS_BITS-1:0]          status
);
	import ust_pkg::*;

	// Command and status bundles between sequencer and datapath.
	ust_cmd_t cmd;
	ust_sts_t sts;

	// Sequencer: owns busy and the one-cycle done strobe.
	ust_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: entry memory, scan compare, live count, result registers.
	// Result fields stay stable from the done cycle until the next transfer.
	ust_dp #(
		.CAPACITY_ENTRIES (CAPACITY_ENTRIES),
		.VALUE_BITS       (VALUE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.opcode  (opcode),
		.value   (value),
		.cmd     (cmd),
		.sts     (sts),
		.present (present),
		.count   (count),
		.status  (status)
	);

	// A full reject only happens when the table holds its capacity.
	localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY_ENTRIES);

	// An accepted transfer must make the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// The strobe only comes once the sequencer is back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// Status codes must agree with the presence flag.
	a_exists_present: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EXISTS) |-> present)
		else $error("exists status without presence");

	a_absent_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((status == ST_ABSENT) || (status == ST_FULL)) |-> !present)
		else $error("absent or full status with presence");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> (count == CAP_COUNT))
		else $error("full status below capacity");

endmodule
`default_nettype wire
